@@ rtl/core/asdc_pkg.sv @@
package asdc_pkg;

	// Register map
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

	localparam logic [15:0] GRAVITY_RST = 16'd2510;
	localparam logic [15:0] GAP_RST     = 16'd280;
	localparam logic [15:0] TIMEOUT_RST = 16'd3000;

	// Fixed-point constants
	localparam logic [15:0] NOISE_KEEP = 16'd64225;
	localparam logic [10:0] NOISE_TAKE = 11'd1311;
	localparam logic [15:0] NOISE_GATE = 16'd640;
	localparam logic [18:0] THR_BASE   = 19'd230;
	localparam logic [8:0]  THR_GAIN   = 9'd461;
	localparam logic [9:0]  THR_MIN    = 10'd256;
	localparam logic [9:0]  THR_MAX    = 10'd563;
	localparam logic [14:0] REL_GAIN   = 15'd27525;
	localparam logic [15:0] ROUND_HALF = 16'd32768;
	localparam int unsigned CAD_SCALE  = 960000;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_NMUL   = 11'b000_0000_0010,
		ST_NADD   = 11'b000_0000_0100,
		ST_TMUL   = 11'b000_0000_1000,
		ST_TCLAMP = 11'b000_0001_0000,
		ST_RMUL   = 11'b000_0010_0000,
		ST_DECIDE = 11'b000_0100_0000,
		ST_SPAN   = 11'b000_1000_0000,
		ST_DIV    = 11'b001_0000_0000,
		ST_CADWR  = 11'b010_0000_0000,
		ST_DONE   = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic load;
		logic noise_mul;
		logic noise_upd;
		logic thr_mul;
		logic thr_clamp;
		logic rel_mul;
		logic decide;
		logic span;
		logic div_step;
		logic cad_write;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic fire;
		logic fill_ok;
		logic span_nz;
		logic div_last;
	} status_t;

endpackage

@@ rtl/core/adaptive_step_detector_cadence.sv @@
// Step detector with an adaptive threshold and a cadence estimate.
// Sample channel: accel_magnitude (Q8.8), now_ms and active, moved by
// sample_valid / sample_stall. Result channel: step_detected, step_total,
// cadence (1/16 spm) and trigger_level (Q8.8), moved by result_valid /
// result_stall. One result word leaves for every sample word taken.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 gravity_level, 1 min_step_gap_ms, 2 cadence_timeout_ms); other
// indexes are dropped. Write only while the block is idle.
// A word that counts a step with two or more ring entries and a nonzero
// span also runs the bit-serial cadence divider over the DW-bit dividend,
// where DW is clog2(960000*(RING_DEPTH-1)+1) (23 at depth 8), and then
// writes cadence; any other word skips the divider.
// One word is worked at a time; sample_stall is high until the result is
// placed in the output register, so a new word can enter while the last
// result still waits. A stalled result holds, and the block then waits with
// the next result until the output register frees.
// Reset loads the register defaults, clears counters, noise and cadence,
// and leaves no result pending.
module adaptive_step_detector_cadence import asdc_pkg::*; #(
	parameter int RING_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  logic [15:0]           accel_magnitude,
	input  logic [31:0]           now_ms,
	input  logic                  active,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  step_detected,
	output logic [31:0]           step_total,
	output logic [15:0]           cadence,
	output logic [9:0]            trigger_level
);

	cmd_t    cmd;
	status_t stat;

	// sequencer: one state per arithmetic step, then the divider loop
	asdc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	// noise filter, threshold, detector state, step ring and divider
	asdc_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.accel_magnitude (accel_magnitude),
		.now_ms          (now_ms),
		.active          (active),
		.cmd             (cmd),
		.stat            (stat),
		.step_detected   (step_detected),
		.step_total      (step_total),
		.cadence         (cadence),
		.trigger_level   (trigger_level)
	);

endmodule

@@ rtl/core/asdc_ctrl.sv @@
module asdc_ctrl import asdc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	output logic    result_valid,
	input  logic    result_stall,
	input  status_t stat,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_room;

	assign out_room     = !out_valid_q || !result_stall;
	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_NMUL;
				end
			end
			ST_NMUL: begin
				cmd.noise_mul = 1'b1;
				state_d       = ST_NADD;
			end
			ST_NADD: begin
				cmd.noise_upd = 1'b1;
				state_d       = ST_TMUL;
			end
			ST_TMUL: begin
				cmd.thr_mul = 1'b1;
				state_d     = ST_TCLAMP;
			end
			ST_TCLAMP: begin
				cmd.thr_clamp = 1'b1;
				state_d       = ST_RMUL;
			end
			ST_RMUL: begin
				cmd.rel_mul = 1'b1;
				state_d     = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_SPAN;
			end
			ST_SPAN: begin
				cmd.span = 1'b1;
				// divide only when a step landed with two or more ring entries and a nonzero span
				if (stat.fire && stat.fill_ok && stat.span_nz) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_CADWR;
				end
			end
			ST_CADWR: begin
				cmd.cad_write = 1'b1;
				state_d       = ST_DONE;
			end
			ST_DONE: begin
				if (out_room) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/asdc_dp.sv @@
module asdc_dp import asdc_pkg::*; #(
	parameter int RING_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [15:0]           accel_magnitude,
	input  logic [31:0]           now_ms,
	input  logic                  active,
	input  cmd_t                  cmd,
	output status_t               stat,
	output logic                  step_detected,
	output logic [31:0]           step_total,
	output logic [15:0]           cadence,
	output logic [9:0]            trigger_level
);

	localparam int HW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FW = $clog2(RING_DEPTH + 1);
	localparam int OW = FW + 1;
	localparam int unsigned DVD_MAX = CAD_SCALE * (RING_DEPTH - 1);
	localparam int DW = $clog2(DVD_MAX + 1);
	localparam int CW = $clog2(DW);

	// configuration
	logic [15:0] gravity_q, gap_q, timeout_q;

	// detector state
	logic [23:0]   noise_q;
	logic          high_q;
	logic [31:0]   counter_q;
	logic [31:0]   last_q;
	logic [HW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [15:0]   cadence_q;

	// per-word working registers
	logic [15:0]   sig_q;
	logic [31:0]   now_q;
	logic          active_q;
	logic [39:0]   keep_prod_q;
	logic [28:0]   take_prod_q;
	logic [32:0]   thr_prod_q;
	logic [9:0]    thr_q;
	logic [9:0]    rel_q;
	logic          fire_q;
	logic [DW-1:0] dvd_q;
	logic [31:0]   ring_rd_q;
	logic [31:0]   span_q;
	logic [31:0]   rem_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;

	logic [31:0] ring_mem [RING_DEPTH];

	logic [15:0]   sig_in;
	logic [40:0]   noise_sum;
	logic [33:0]   thr_sum;
	logic [18:0]   thr_raw;
	logic [9:0]    thr_next;
	logic [25:0]   rel_sum;
	logic [31:0]   elapsed;
	logic          fire, release_hit;
	logic [HW-1:0] head_new;
	logic [FW-1:0] fill_new;
	logic [OW-1:0] oldest_sum;
	logic [HW-1:0] oldest;
	logic [32:0]   trial;
	logic          trial_ge;
	logic [15:0]   cad_sat;

	assign sig_in = (accel_magnitude >= gravity_q) ? accel_magnitude - gravity_q
	                                               : gravity_q - accel_magnitude;

	assign noise_sum = {1'b0, keep_prod_q} + 41'(take_prod_q) + 41'(ROUND_HALF);

	assign thr_sum = {1'b0, thr_prod_q} + 34'(ROUND_HALF);
	assign thr_raw = 19'(thr_sum[33:16]) + THR_BASE;

	always_comb begin
		if (thr_raw < 19'(THR_MIN)) begin
			thr_next = THR_MIN;
		end else if (thr_raw > 19'(THR_MAX)) begin
			thr_next = THR_MAX;
		end else begin
			thr_next = thr_raw[9:0];
		end
	end

	assign rel_sum = 26'(thr_q) * 26'(REL_GAIN) + 26'(ROUND_HALF);

	assign elapsed     = now_q - last_q;
	assign fire        = active_q && !high_q && (sig_q > 16'(thr_q)) && (elapsed >= 32'(gap_q));
	assign release_hit = active_q && high_q && (sig_q < 16'(rel_q));

	// ring pointers as they stand after this step is stored
	assign head_new = (head_q == HW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign fill_new = (fill_q == FW'(RING_DEPTH)) ? fill_q : fill_q + 1'b1;
	assign oldest_sum = OW'(head_new) + OW'(RING_DEPTH) - OW'(fill_new);
	assign oldest = (oldest_sum >= OW'(RING_DEPTH)) ? HW'(oldest_sum - OW'(RING_DEPTH))
	                                                 : HW'(oldest_sum);

	assign trial    = {rem_q, quo_q[DW-1]};
	assign trial_ge = (trial >= {1'b0, span_q});

	assign cad_sat = (|quo_q[DW-1:16]) ? 16'hFFFF : quo_q[15:0];

	assign stat.fire     = fire_q;
	assign stat.fill_ok  = (fill_q >= FW'(2));
	assign stat.span_nz  = ((now_q - ring_rd_q) != 32'd0);
	assign stat.div_last = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= GRAVITY_RST;
			gap_q     <= GAP_RST;
			timeout_q <= TIMEOUT_RST;
			noise_q   <= '0;
			high_q    <= 1'b0;
			counter_q <= '0;
			last_q    <= '0;
			head_q    <= '0;
			fill_q    <= '0;
			cadence_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRAVITY: gravity_q <= cfg_data;
					REG_GAP:     gap_q     <= cfg_data;
					REG_TIMEOUT: timeout_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.noise_upd && active_q && !high_q && (sig_q < NOISE_GATE)) begin
				noise_q <= noise_sum[39:16];
			end
			if (cmd.decide) begin
				if (fire) begin
					high_q    <= 1'b1;
					counter_q <= counter_q + 32'd1;
					last_q    <= now_q;
					head_q    <= head_new;
					fill_q    <= fill_new;
				end else begin
					if (release_hit) begin
						high_q <= 1'b0;
					end
					if (active_q && (elapsed > 32'(timeout_q))) begin
						cadence_q <= '0;
					end
				end
			end
			if (cmd.cad_write) begin
				cadence_q <= cad_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sig_q    <= sig_in;
			now_q    <= now_ms;
			active_q <= active;
		end
		if (cmd.noise_mul) begin
			keep_prod_q <= 40'(noise_q) * 40'(NOISE_KEEP);
			take_prod_q <= 29'({sig_q[9:0], 8'd0}) * 29'(NOISE_TAKE);
		end
		if (cmd.thr_mul) begin
			thr_prod_q <= 33'(noise_q) * 33'(THR_GAIN);
		end
		if (cmd.thr_clamp) begin
			thr_q <= thr_next;
		end
		if (cmd.rel_mul) begin
			rel_q <= rel_sum[25:16];
		end
		if (cmd.decide) begin
			fire_q <= fire;
			dvd_q  <= DW'(CAD_SCALE) * DW'(fill_new - 1'b1);
		end
		if (cmd.span) begin
			span_q <= now_q - ring_rd_q;
			rem_q  <= '0;
			quo_q  <= dvd_q;
			cnt_q  <= CW'(DW - 1);
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? 32'(trial - {1'b0, span_q}) : trial[31:0];
			quo_q <= {quo_q[DW-2:0], trial_ge};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.out_load) begin
			step_detected <= fire_q;
			step_total    <= counter_q;
			cadence       <= cadence_q;
			trigger_level <= thr_q;
		end
	end

	// step time ring: write the new step, read the oldest kept time
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			if (fire) begin
				ring_mem[head_q] <= now_q;
			end
			ring_rd_q <= ring_mem[oldest];
		end
	end

endmodule

@@ dv/adaptive_step_detector_cadence_tb.sv @@
`timescale 1ns / 1ps

module adaptive_step_detector_cadence_tb;
	import asdc_pkg::*;

	// Own copy of the fixed-point constants of the detector
	localparam int unsigned NOISE_HOLD   = 64225;
	localparam int unsigned NOISE_GAIN   = 1311;
	localparam int unsigned QUIET_LIMIT  = 640;
	localparam int unsigned THR_OFFSET   = 230;
	localparam int unsigned THR_SLOPE    = 461;
	localparam int unsigned LEVEL_MIN    = 256;
	localparam int unsigned LEVEL_MAX    = 563;
	localparam int unsigned RELEASE_GAIN = 27525;
	localparam int unsigned HALF_LSB     = 32768;
	localparam int unsigned SPM16_SCALE  = 960000;
	localparam int unsigned RING_N       = 8;
	localparam int unsigned SETTLE_CYCLES = 60;

	// Index 3 decodes to no register; writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [15:0] accel;
		logic [31:0] now;
		logic        act;
	} sample_t;

	typedef struct packed {
		logic        det;
		logic [31:0] total;
		logic [15:0] cad;
		logic [9:0]  trig;
	} step_report_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  sample_valid;
	logic                  sample_stall;
	logic [15:0]           accel_magnitude;
	logic [31:0]           now_ms;
	logic                  active;
	logic                  result_valid;
	logic                  result_stall;
	logic                  step_detected;
	logic [31:0]           step_total;
	logic [15:0]           cadence;
	logic [9:0]            trigger_level;

	adaptive_step_detector_cadence DUT (.*);

	sample_t      pending_samples[$];
	step_report_t expected_reports[$];
	logic         sample_taken = 1'b0;
	int unsigned  mismatch_count = 0;
	int unsigned  queued_count = 0;
	int unsigned  sender_idle_pct = 0;
	int unsigned  receiver_idle_pct = 0;
	logic [31:0]  clock_ms = '0;

	// Register mirror, tracks every write the block sees
	logic [15:0] grav_cfg = 16'd2510;
	logic [15:0] gap_cfg = 16'd280;
	logic [15:0] timeout_cfg = 16'd3000;

	// Detector state as predicted
	logic [31:0] steps_seen = '0;
	logic [31:0] last_step_ms = '0;
	logic [31:0] step_ring [RING_N];
	logic [2:0]  ring_wr = '0;
	logic [3:0]  ring_count = '0;
	logic        pulse_high = 1'b0;
	logic [23:0] noise_q = '0;
	logic [15:0] cadence_q = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Threshold in Q8.8 from the noise average, clamped to its legal band
	function automatic logic [9:0] level_from_noise(input logic [23:0] n);
		logic [63:0] t;
		t = 64'(THR_OFFSET) + ((64'(n) * THR_SLOPE + HALF_LSB) >> 16);
		if (t < LEVEL_MIN)
			t = LEVEL_MIN;
		if (t > LEVEL_MAX)
			t = LEVEL_MAX;
		return t[9:0];
	endfunction

	// Advance the predicted detector by one sample word and queue its report
	task automatic track_sample(input sample_t s);
		logic [15:0]  sig;
		logic [9:0]   thr;
		logic [63:0]  prod;
		logic [31:0]  rel;
		logic [31:0]  elapsed;
		logic [31:0]  span;
		logic [2:0]   newest;
		logic [2:0]   oldest;
		step_report_t rep;
		rep = '0;
		if (s.act) begin
			sig = (s.accel >= grav_cfg) ? s.accel - grav_cfg : grav_cfg - s.accel;
			// noise only follows quiet samples taken while the detector is low
			if (!pulse_high && sig < QUIET_LIMIT) begin
				prod = 64'(NOISE_HOLD) * noise_q + 64'(NOISE_GAIN) * (64'(sig) << 8)
					+ HALF_LSB;
				noise_q = prod[39:16];
			end
			thr = level_from_noise(noise_q);
			prod = (64'(thr) * RELEASE_GAIN + HALF_LSB) >> 16;
			rel = prod[31:0];
			elapsed = s.now - last_step_ms;
			if (!pulse_high && sig > thr && elapsed >= 32'(gap_cfg)) begin
				pulse_high = 1'b1;
				rep.det = 1'b1;
				steps_seen = steps_seen + 32'd1;
				last_step_ms = s.now;
				step_ring[ring_wr] = s.now;
				ring_wr = ring_wr + 3'd1;
				if (ring_count < RING_N)
					ring_count = ring_count + 4'd1;
				if (ring_count >= 4'd2) begin
					newest = ring_wr - 3'd1;
					oldest = 3'(4'(ring_wr) - ring_count);
					span = step_ring[newest] - step_ring[oldest];
					// equal newest and oldest times leave cadence alone
					if (span != 0) begin
						prod = (64'(SPM16_SCALE) * 64'(ring_count - 4'd1)) / 64'(span);
						cadence_q = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
					end
				end
			end else if (pulse_high && sig < rel) begin
				pulse_high = 1'b0;
			end
			elapsed = s.now - last_step_ms;
			if (elapsed > 32'(timeout_cfg))
				cadence_q = '0;
		end
		rep.total = steps_seen;
		rep.cad = cadence_q;
		rep.trig = level_from_noise(noise_q);
		expected_reports.push_back(rep);
	endtask

	// Driver: present the oldest pending word at the falling edge, hold it
	// while stalled, drop it once the rising edge has taken it
	always @(negedge clk) begin
		logic next_valid;
		if (arst_n) begin
			next_valid = sample_valid;
			if (sample_taken) begin
				sample_taken = 1'b0;
				void'(pending_samples.pop_front());
				next_valid = 1'b0;
			end
			if (!next_valid && pending_samples.size() != 0 &&
			    $urandom_range(0, 99) >= sender_idle_pct) begin
				next_valid = 1'b1;
				accel_magnitude <= pending_samples[0].accel;
				now_ms <= pending_samples[0].now;
				active <= pending_samples[0].act;
			end
			sample_valid <= next_valid;
			result_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
		end
	end

	// Monitor: mirror register writes, predict on every accepted sample word,
	// check every accepted result word against the oldest expectation
	always @(posedge clk) begin
		step_report_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GRAVITY: grav_cfg = cfg_data;
					REG_GAP:     gap_cfg = cfg_data;
					REG_TIMEOUT: timeout_cfg = cfg_data;
					default:     ;
				endcase
			end
			if (sample_valid && !sample_stall) begin
				track_sample('{accel: accel_magnitude, now: now_ms, act: active});
				sample_taken = 1'b1;
			end
			if (result_valid && !result_stall) begin
				if (expected_reports.size() == 0) begin
					$error("result word arrived with no sample pending");
					mismatch_count++;
				end else begin
					want = expected_reports.pop_front();
					if (step_detected !== want.det) begin
						$error("step_detected: expected %0d, got %0d", want.det, step_detected);
						mismatch_count++;
					end
					if (step_total !== want.total) begin
						$error("step_total: expected %0d, got %0d", want.total, step_total);
						mismatch_count++;
					end
					if (cadence !== want.cad) begin
						$error("cadence: expected %0d, got %0d", want.cad, cadence);
						mismatch_count++;
					end
					if (trigger_level !== want.trig) begin
						$error("trigger_level: expected %0d, got %0d", want.trig,
							trigger_level);
						mismatch_count++;
					end
				end
			end
		end
	end

	task automatic queue_sample(input logic [15:0] a, input logic [31:0] t, input logic act);
		pending_samples.push_back('{accel: a, now: t, act: act});
		queued_count++;
	endtask

	// Level at a given distance from gravity, on whichever side fits
	function automatic logic [15:0] beside_gravity(input int unsigned amp);
		int unsigned g;
		g = grav_cfg;
		if (($urandom_range(0, 1) == 1 || g < amp) && g + amp <= 65535)
			return 16'(g + amp);
		return 16'(g - amp);
	endfunction

	// Wait until every word has gone through, then let the pipeline drain
	task automatic settle();
		while (pending_samples.size() != 0 || sample_valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
		sender_idle_pct = sender_pct;
		receiver_idle_pct = receiver_pct;
	endtask

	// Steady walk: one sharp peak per stride, quiet samples in between
	task automatic queue_walk();
		int unsigned period;
		int unsigned amp;
		int unsigned spacing;
		int unsigned strides;
		int unsigned i;
		int unsigned j;
		logic [15:0] a;
		period = $urandom_range(260, 800);
		amp = $urandom_range(300, 1600);
		spacing = $urandom_range(15, 30);
		strides = $urandom_range(2, 6);
		for (i = 0; i < strides; i++) begin
			for (j = 0; j < period / spacing; j++) begin
				clock_ms = clock_ms + spacing + $urandom_range(0, 4) - 2;
				if (j == 1)
					a = beside_gravity(amp);
				else if (j == 0 || j == 2)
					a = beside_gravity(amp / 2);
				else
					a = beside_gravity($urandom_range(0, 180));
				queue_sample(a, clock_ms, $urandom_range(0, 39) != 0);
			end
		end
	endtask

	// Peaks packed close together, with time going backwards now and then
	task automatic queue_jitter();
		int unsigned n;
		int unsigned i;
		n = $urandom_range(3, 10);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0)
				clock_ms = clock_ms - $urandom_range(0, 500);
			else
				clock_ms = clock_ms + $urandom_range(0, 200);
			queue_sample(beside_gravity($urandom_range(200, 3000)), clock_ms, 1'b1);
			queue_sample(beside_gravity($urandom_range(0, 400)), clock_ms, 1'b1);
		end
	endtask

	// Raw noise across the whole field range
	task automatic queue_noise();
		int unsigned n;
		int unsigned i;
		n = $urandom_range(4, 20);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				clock_ms = $urandom;
			else
				clock_ms = clock_ms + $urandom_range(0, 60);
			queue_sample(16'($urandom_range(0, 65535)), clock_ms, $urandom_range(0, 1) == 1);
		end
	endtask

	// Stand still past the cadence timeout, then take one stride
	task automatic queue_pause();
		clock_ms = clock_ms + timeout_cfg + $urandom_range(1, 3000);
		queue_sample(beside_gravity($urandom_range(0, 100)), clock_ms, 1'b1);
		clock_ms = clock_ms + $urandom_range(10, 40);
		queue_sample(beside_gravity($urandom_range(600, 2000)), clock_ms, 1'b1);
		clock_ms = clock_ms + $urandom_range(10, 40);
		queue_sample(beside_gravity($urandom_range(0, 100)), clock_ms, 1'b1);
	endtask

	// Many steps at one timestamp; with no refractory gap the ring fills with
	// equal times and the span collapses to zero
	task automatic queue_stutter(input int unsigned n);
		int unsigned i;
		for (i = 0; i < n; i++) begin
			queue_sample(beside_gravity(1500), clock_ms, 1'b1);
			queue_sample(grav_cfg, clock_ms, 1'b1);
		end
	endtask

	task automatic run_random_phase(input int unsigned target);
		int unsigned first;
		first = queued_count;
		case ($urandom_range(0, 2))
			0:       clock_ms = $urandom;
			1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			default: clock_ms = $urandom_range(0, 5000);
		endcase
		if (gap_cfg == 0)
			queue_stutter(RING_N + 2);
		while (queued_count - first < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: queue_walk();
				6:                queue_jitter();
				7:                queue_noise();
				8:                queue_pause();
				default:          queue_stutter($urandom_range(1, 4));
			endcase
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_GRAVITY;
		cfg_data = '0;
		sample_valid = 1'b0;
		accel_magnitude = '0;
		now_ms = '0;
		active = 1'b0;
		result_stall = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under reset defaults
		set_idling(29, 82);
		queue_sample(16'hFFFF, 32'hFFFF_FFFF, 1'b0);	// inactive, extremes
		queue_sample(16'd2510, 32'd0, 1'b1);
		queue_sample(16'd0, 32'd100, 1'b1);	// first step still inside gap from zero
		queue_sample(16'hFFFF, 32'd300, 1'b1);	// first counted step
		queue_sample(16'd2510, 32'd310, 1'b1);	// release
		queue_sample(16'd5000, 32'd400, 1'b1);	// refractory, no step
		queue_sample(16'd2510, 32'd420, 1'b1);
		queue_sample(16'd5000, 32'd700, 1'b1);	// second step, first cadence
		queue_sample(16'd2510, 32'd710, 1'b1);
		queue_sample(16'd5000, 32'd1000, 1'b1);
		queue_sample(16'd2510, 32'd1010, 1'b1);
		queue_sample(16'd2510, 32'd5000, 1'b1);	// idle past timeout, cadence clears
		queue_sample(16'd0, 32'd0, 1'b0);	// inactive reports current state
		queue_sample(16'd3149, 32'd5010, 1'b1);	// just under the noise gate
		queue_sample(16'd3149, 32'd5020, 1'b1);
		queue_sample(16'd3149, 32'd5030, 1'b1);
		queue_sample(16'd3150, 32'd5040, 1'b1);	// at the gate
		queue_sample(16'd2510, 32'd5050, 1'b1);
		queue_sample(16'd2510, 32'hFFFF_FF00, 1'b1);
		queue_sample(16'd5000, 32'hFFFF_FFF0, 1'b1);
		queue_sample(16'd2510, 32'hFFFF_FFF8, 1'b1);
		queue_sample(16'd5000, 32'h0000_0200, 1'b1);	// step across the time wrap
		settle();

		write_reg(REG_GRAVITY, 16'd0);
		write_reg(REG_GAP, 16'd0);
		write_reg(REG_TIMEOUT, 16'hFFFF);
		write_reg(REG_UNUSED, 16'hA5A5);	// must be ignored
		queue_sample(16'd0, 32'h0000_0200, 1'b1);
		queue_sample(16'hFFFF, 32'h0000_0200, 1'b1);	// no gap, same time
		settle();

		// Random part: extremes first, then ordinary and random settings
		write_reg(REG_GRAVITY, 16'd2510);
		write_reg(REG_GAP, 16'd0);
		write_reg(REG_TIMEOUT, 16'd0);
		run_random_phase(245);

		write_reg(REG_GRAVITY, 16'hFFFF);
		write_reg(REG_GAP, 16'hFFFF);
		write_reg(REG_TIMEOUT, 16'hFFFF);
		run_random_phase(245);

		set_idling(82, 29);
		write_reg(REG_GRAVITY, 16'($urandom_range(2300, 2700)));
		write_reg(REG_GAP, 16'($urandom_range(150, 400)));
		write_reg(REG_TIMEOUT, 16'($urandom_range(1500, 5000)));
		run_random_phase(245);

		write_reg(REG_GRAVITY, 16'd0);
		write_reg(REG_GAP, 16'($urandom_range(0, 600)));
		write_reg(REG_TIMEOUT, 16'($urandom_range(500, 8000)));
		run_random_phase(245);

		set_idling(0, 0);
		write_reg(REG_GRAVITY, 16'd2510);
		write_reg(REG_GAP, 16'd280);
		write_reg(REG_TIMEOUT, 16'd3000);
		run_random_phase(245);

		write_reg(REG_GRAVITY, 16'($urandom_range(0, 65535)));
		write_reg(REG_GAP, 16'd0);
		write_reg(REG_TIMEOUT, 16'($urandom_range(0, 65535)));
		run_random_phase(245);

		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/asdc_pkg.sv
rtl/core/asdc_ctrl.sv
rtl/core/asdc_dp.sv
rtl/core/adaptive_step_detector_cadence.sv
dv/adaptive_step_detector_cadence_tb.sv
